[rtl/grc_pkg.sv]
`default_nettype none

package grc_pkg;

    // Map geometry: a square bitmap, row-major, one bit per cell.
    localparam int POS_W     = 9;
    localparam int MAP_SIDE  = 2 ** POS_W;
    localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
    localparam int MAP_AW    = 2 * POS_W;

    // Direction steps per turn; the quadrant folding needs a multiple of four.
    // The angle field is narrow enough that one subtraction wraps it.
    localparam int ANGLE_STEPS = 360;
    localparam int QUAD_STEPS  = ANGLE_STEPS / 4;
    localparam int ANG_W       = 9;
    localparam int QIDX_W      = $clog2(QUAD_STEPS);

    // Radius, trig magnitude (Q1.16 without sign) and the offset accumulators.
    localparam int RANGE_W = 8;
    localparam int FRAC_W  = 16;
    localparam int TRIG_W  = FRAC_W + 1;
    localparam int ACC_W   = TRIG_W + RANGE_W;
    localparam int DX_W    = ACC_W - FRAC_W;
    localparam int COORD_W = ((POS_W > DX_W) ? POS_W : DX_W) + 2;

    // Queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration port.
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int CFG_IDX_W = APB_AW - 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = '0;
    localparam logic [RANGE_W-1:0]   MAX_RANGE_RESET = 8'd80;

    // Item commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    // Constants of the first-quadrant series evaluation.
    localparam int TAYLOR_TERMS = 10;
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV_C [TAYLOR_TERMS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};
    localparam longint unsigned TAYLOR_DIV_S [TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef logic [TRIG_W-1:0] quad_tab_t [QUAD_STEPS];

    // Work item passed from the front end to the back end.
    typedef struct packed {
        logic              cmd;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic              cell_free;
        logic [TRIG_W-1:0] cos_mag;
        logic              cos_neg;
        logic [TRIG_W-1:0] sin_mag;
        logic              sin_neg;
    } work_t;

    // Cosine or sine of each first-quadrant step, Q30 series rounded to Q16.
    // Evaluated at elaboration only.
    function automatic quad_tab_t build_quad_tab(input logic want_sin);
        quad_tab_t       tab;
        longint unsigned phi;
        longint unsigned p2;
        longint unsigned tc;
        longint unsigned ts;
        longint          ac;
        longint          sv;
        longint          pick;
        for (int j = 0; j < QUAD_STEPS; j++) begin
            phi = (HALF_PI_Q30 * longint'(4 * j)) / ANGLE_STEPS;
            p2  = (phi * phi) >> 30;
            tc  = Q30_ONE;
            ts  = phi;
            ac  = longint'(Q30_ONE);
            sv  = longint'(phi);
            for (int n = 0; n < TAYLOR_TERMS; n++) begin
                tc = ((tc * p2) >> 30) / TAYLOR_DIV_C[n];
                ts = ((ts * p2) >> 30) / TAYLOR_DIV_S[n];
                if (n % 2 == 0) begin
                    ac = ac - longint'(tc);
                    sv = sv - longint'(ts);
                end
                else begin
                    ac = ac + longint'(tc);
                    sv = sv + longint'(ts);
                end
            end
            pick = want_sin ? sv : ac;
            if (pick < 0) begin
                pick = 0;
            end
            tab[j] = TRIG_W'(($unsigned(pick) + 64'd8192) >> 14);
        end
        return tab;
    endfunction

    localparam quad_tab_t QUAD_COS = build_quad_tab(1'b0);
    localparam quad_tab_t QUAD_SIN = build_quad_tab(1'b1);

endpackage

`default_nettype wire

[rtl/grc_if.sv]
`default_nettype none

// Input item channel.
interface grc_item_if;
    import grc_pkg::*;

    logic             valid;
    logic             ready;
    logic             cmd;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             cell_free;
    logic [ANG_W-1:0] angle_deg;

    modport source (output valid, cmd, pos_x, pos_y, cell_free, angle_deg, input ready);
    modport sink (input valid, cmd, pos_x, pos_y, cell_free, angle_deg, output ready);
endinterface

// Result channel.
interface grc_result_if;
    import grc_pkg::*;

    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_cells;

    modport source (output valid, range_cells, input ready);
    modport sink (input valid, range_cells, output ready);
endinterface

`default_nettype wire

[rtl/grid_ray_cast_range.sv]
// A write item passes through the queue and is written into the map when the idle back end
// pops it; a cast reports the radius of its first blocked or off-map cell, max_range if no
// cell blocks it, and zero when max_range is zero.
// Throughput: one radius step per cycle, set by the single read port of the map memory; the
// back end takes no new item until a cast has registered its result, and a write retires at once.
// Reset clears all control state and sets max_range to 80; map contents stay undefined.
`default_nettype none

module grid_ray_cast_range (
    input  wire                          clk,
    input  wire                          rst_n,
    grc_item_if.sink                     item,
    grc_result_if.source                 result,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [grc_pkg::APB_AW-1:0]    paddr,
    input  wire [grc_pkg::APB_DW-1:0]    pwdata,
    output logic [grc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import grc_pkg::*;

    logic [RANGE_W-1:0]   max_range_reg;
    logic [RANGE_W-1:0]   max_range_next;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;
    logic                 push;
    logic                 full;
    logic                 avail;
    logic                 pop;
    work_t                push_work;
    work_t                head;

    // Register file: one register, written on the access phase.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[APB_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        max_range_next = max_range_reg;
        if (cfg_wr && cfg_idx == REG_MAX_RANGE)
        begin
            max_range_next = pwdata[RANGE_W-1:0];
        end
        if (cfg_idx == REG_MAX_RANGE)
        begin
            prdata = APB_DW'(max_range_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_reg <= MAX_RANGE_RESET;
        end
        else
        begin
            max_range_reg <= max_range_next;
        end
    end

    // Front end: accepts and classifies items.
    grc_front u_front (
        .item (item),
        .full (full),
        .push (push),
        .work (push_work)
    );

    // Queue between front and back end.
    grc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_work (push_work),
        .pop       (pop),
        .full      (full),
        .avail     (avail),
        .head      (head)
    );

    // Back end: map writes and ray stepping.
    grc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_range (max_range_reg),
        .avail     (avail),
        .head      (head),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

[rtl/grc_ram.sv]
`default_nettype none

module grc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire                     re,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/grc_front.sv]
`default_nettype none

module grc_front (
    grc_item_if.sink        item,
    input  wire             full,
    output logic            push,
    output grc_pkg::work_t  work
);
    import grc_pkg::*;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    logic [ANG_W-1:0]  ang_wrap;
    logic [ANG_W-1:0]  quad_base;
    logic [1:0]        quad;
    logic [QIDX_W-1:0] qidx;
    logic [TRIG_W-1:0] c_mag;
    logic [TRIG_W-1:0] s_mag;

    // Accept whenever the queue has room.
    assign item.ready = !full;
    assign push       = item.valid && !full;

    // Wrap the direction, fold it into the first quadrant and look up the table.
    always_comb
    begin
        if (item.angle_deg >= ANG_W'(ANGLE_STEPS))
        begin
            ang_wrap = item.angle_deg - ANG_W'(ANGLE_STEPS);
        end
        else
        begin
            ang_wrap = item.angle_deg;
        end

        if (ang_wrap >= ANG_W'(3 * QUAD_STEPS))
        begin
            quad      = QUAD_FOURTH;
            quad_base = ANG_W'(3 * QUAD_STEPS);
        end
        else if (ang_wrap >= ANG_W'(2 * QUAD_STEPS))
        begin
            quad      = QUAD_THIRD;
            quad_base = ANG_W'(2 * QUAD_STEPS);
        end
        else if (ang_wrap >= ANG_W'(QUAD_STEPS))
        begin
            quad      = QUAD_SECOND;
            quad_base = ANG_W'(QUAD_STEPS);
        end
        else
        begin
            quad      = QUAD_FIRST;
            quad_base = '0;
        end

        qidx  = QIDX_W'(ang_wrap - quad_base);
        c_mag = QUAD_COS[qidx];
        s_mag = QUAD_SIN[qidx];
    end

    // Build the work item: sign and magnitude of each direction component.
    always_comb
    begin
        work.cmd       = item.cmd;
        work.px        = item.pos_x;
        work.py        = item.pos_y;
        work.cell_free = item.cell_free;
        work.cos_mag   = (quad inside {QUAD_SECOND, QUAD_FOURTH}) ? s_mag : c_mag;
        work.sin_mag   = (quad inside {QUAD_SECOND, QUAD_FOURTH}) ? c_mag : s_mag;
        work.cos_neg   = (quad inside {QUAD_SECOND, QUAD_THIRD});
        work.sin_neg   = (quad inside {QUAD_THIRD, QUAD_FOURTH});
    end

endmodule

`default_nettype wire

[rtl/grc_queue.sv]
`default_nettype none

module grc_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  wire grc_pkg::work_t push_work,
    input  wire             pop,
    output logic            full,
    output logic            avail,
    output grc_pkg::work_t  head
);
    import grc_pkg::*;

    work_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign avail = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_work;
        end
    end

endmodule

`default_nettype wire

[rtl/grc_back.sv]
`default_nettype none

module grc_back (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire [grc_pkg::RANGE_W-1:0]     max_range,
    input  wire                            avail,
    input  wire grc_pkg::work_t            head,
    output logic                           pop,
    grc_result_if.source                   result
);
    import grc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CAST,
        S_RESULT
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [POS_W-1:0]   px_reg;
    logic [POS_W-1:0]   px_next;
    logic [POS_W-1:0]   py_reg;
    logic [POS_W-1:0]   py_next;
    logic [TRIG_W-1:0]  cmag_reg;
    logic [TRIG_W-1:0]  cmag_next;
    logic [TRIG_W-1:0]  smag_reg;
    logic [TRIG_W-1:0]  smag_next;
    logic               cneg_reg;
    logic               cneg_next;
    logic               sneg_reg;
    logic               sneg_next;
    logic [RANGE_W-1:0] issue_r_reg;
    logic [RANGE_W-1:0] issue_r_next;
    logic [ACC_W-1:0]   accx_reg;
    logic [ACC_W-1:0]   accx_next;
    logic [ACC_W-1:0]   accy_reg;
    logic [ACC_W-1:0]   accy_next;
    logic               bval_reg;
    logic               bval_next;
    logic [RANGE_W-1:0] br_reg;
    logic [RANGE_W-1:0] br_next;
    logic               binb_reg;
    logic               binb_next;
    logic [RANGE_W-1:0] res_reg;
    logic [RANGE_W-1:0] res_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [RANGE_W-1:0] out_range_reg;
    logic [RANGE_W-1:0] out_range_next;

    logic               issue;
    logic [COORD_W-1:0] px_ext;
    logic [COORD_W-1:0] py_ext;
    logic [COORD_W-1:0] dx_ext;
    logic [COORD_W-1:0] dy_ext;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic               inb;
    logic               blocked;
    logic               last_step;
    logic               ram_we;
    logic               ram_re;
    logic [MAP_AW-1:0]  ram_waddr;
    logic [MAP_AW-1:0]  ram_raddr;
    logic               ram_wdata;
    logic               ram_rdata;

    // Map storage: one bit per cell, read once per radius step.
    grc_ram #(
        .WIDTH (1),
        .DEPTH (MAP_CELLS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign result.valid       = out_valid_reg;
    assign result.range_cells = out_range_reg;

    // Cell at the current radius; the offsets truncate toward zero.
    always_comb
    begin
        px_ext = COORD_W'(px_reg);
        py_ext = COORD_W'(py_reg);
        dx_ext = COORD_W'(accx_reg[ACC_W-1:FRAC_W]);
        dy_ext = COORD_W'(accy_reg[ACC_W-1:FRAC_W]);
        cx     = cneg_reg ? px_ext - dx_ext : px_ext + dx_ext;
        cy     = sneg_reg ? py_ext - dy_ext : py_ext + dy_ext;
        inb    = !cx[COORD_W-1] && (cx < COORD_W'(MAP_SIDE))
              && !cy[COORD_W-1] && (cy < COORD_W'(MAP_SIDE));
        ram_raddr = {cy[POS_W-1:0], cx[POS_W-1:0]};
        ram_waddr = {head.py, head.px};
        ram_wdata = head.cell_free;
        issue     = (issue_r_reg < max_range);
        blocked   = !binb_reg || !ram_rdata;
        last_step = ((br_reg + RANGE_W'(1)) == max_range);
    end

    // Sequencer: write items retire at once, casts step the radius with
    // one map read per cycle and the check of each read in the cycle after it.
    always_comb
    begin
        state_next     = state_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        cmag_next      = cmag_reg;
        smag_next      = smag_reg;
        cneg_next      = cneg_reg;
        sneg_next      = sneg_reg;
        issue_r_next   = issue_r_reg;
        accx_next      = accx_reg;
        accy_next      = accy_reg;
        bval_next      = 1'b0;
        br_next        = br_reg;
        binb_next      = binb_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_range_next = out_range_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (avail)
                begin
                    pop = 1'b1;
                    if (head.cmd == CMD_WRITE)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        px_next      = head.px;
                        py_next      = head.py;
                        cmag_next    = head.cos_mag;
                        smag_next    = head.sin_mag;
                        cneg_next    = head.cos_neg;
                        sneg_next    = head.sin_neg;
                        issue_r_next = '0;
                        accx_next    = '0;
                        accy_next    = '0;
                        if (max_range == '0)
                        begin
                            res_next   = '0;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_CAST;
                        end
                    end
                end
            end
            S_CAST:
            begin
                if (issue)
                begin
                    ram_re       = 1'b1;
                    issue_r_next = issue_r_reg + RANGE_W'(1);
                    accx_next    = accx_reg + ACC_W'(cmag_reg);
                    accy_next    = accy_reg + ACC_W'(smag_reg);
                    bval_next    = 1'b1;
                    br_next      = issue_r_reg;
                    binb_next    = inb;
                end
                if (bval_reg && blocked)
                begin
                    res_next   = br_reg;
                    bval_next  = 1'b0;
                    state_next = S_RESULT;
                end
                else if (bval_reg && last_step)
                begin
                    res_next   = max_range;
                    bval_next  = 1'b0;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_range_next = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            px_reg        <= '0;
            py_reg        <= '0;
            cmag_reg      <= '0;
            smag_reg      <= '0;
            cneg_reg      <= 1'b0;
            sneg_reg      <= 1'b0;
            issue_r_reg   <= '0;
            accx_reg      <= '0;
            accy_reg      <= '0;
            bval_reg      <= 1'b0;
            br_reg        <= '0;
            binb_reg      <= 1'b0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_range_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            cmag_reg      <= cmag_next;
            smag_reg      <= smag_next;
            cneg_reg      <= cneg_next;
            sneg_reg      <= sneg_next;
            issue_r_reg   <= issue_r_next;
            accx_reg      <= accx_next;
            accy_reg      <= accy_next;
            bval_reg      <= bval_next;
            br_reg        <= br_next;
            binb_reg      <= binb_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_range_reg <= out_range_next;
        end
    end

    // The issue radius never runs past the configured range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CAST) |-> (issue_r_reg <= max_range))
        else $error("issue radius beyond max_range");

    // The radius under check is always the one issued just before.
    assert property (@(posedge clk) disable iff (!rst_n)
        bval_reg |-> (issue_r_reg == br_reg + RANGE_W'(1)))
        else $error("check stage out of step with issue stage");

    // A pending answer never exceeds the configured range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT) |-> (res_reg <= max_range))
        else $error("answer beyond max_range");

    // A result only appears after the sequencer held it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_RESULT))
        else $error("result shown without a finished cast");

endmodule

`default_nettype wire

[tb/sv/grid_ray_cast_range_test.sv]
`default_nettype none

module grid_ray_cast_range_test;
    import grc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int WRITE_SETTLE   = 8;
    localparam int TAIL_CYCLES    = 300;
    localparam int HOLD_CYCLES    = 600;
    localparam int WINDOW         = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 1'b1;
    localparam logic [APB_AW-1:0]    MAX_RANGE_ADDR = {REG_MAX_RANGE, 2'b00};
    localparam logic [APB_AW-1:0]    SPARE_ADDR     = {REG_SPARE, 2'b00};
    localparam logic [POS_W-1:0]     EDGE_HI        = POS_W'(MAP_SIDE - 1);
    localparam logic [ANG_W-1:0]     ANGLE_TOP      = '1;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    grc_item_if   item_ch ();
    grc_result_if result_ch ();

    // Direction tables in Q2.16 and the map as the block should hold it.
    int          dir_cos [ANGLE_STEPS];
    int          dir_sin [ANGLE_STEPS];
    bit          cell_free_map [MAP_CELLS];
    bit          cell_written [MAP_CELLS];
    int unsigned range_limit;

    logic [RANGE_W-1:0] pending_ranges [$];

    int errors = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    grid_ray_cast_range dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // Q30 value to Q16, clamped at zero and rounded to nearest.
    function automatic int round_to_q16(input longint v);
        if (v < 0) begin
            v = 0;
        end
        return int'(($unsigned(v) + 64'd8192) >> 14);
    endfunction

    // First-quadrant series in Q30, folded into all four quadrants.
    function automatic void build_direction_tables();
        longint unsigned phi;
        longint unsigned p2;
        longint unsigned tc;
        longint unsigned ts;
        longint unsigned n;
        longint          cos_acc;
        longint          sin_acc;
        int              quad;
        int              rem;
        int              c;
        int              s;
        for (int k = 0; k < ANGLE_STEPS; k++) begin
            quad = (4 * k) / ANGLE_STEPS;
            rem = 4 * k - quad * ANGLE_STEPS;
            phi = (HALF_PI_Q30 * longint'(rem)) / ANGLE_STEPS;
            p2 = (phi * phi) >> 30;
            tc = Q30_ONE;
            ts = phi;
            cos_acc = longint'(Q30_ONE);
            sin_acc = longint'(phi);
            for (n = 1; n <= TAYLOR_TERMS; n++) begin
                tc = ((tc * p2) >> 30) / ((2 * n - 1) * (2 * n));
                ts = ((ts * p2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n[0]) begin
                    cos_acc = cos_acc - longint'(tc);
                    sin_acc = sin_acc - longint'(ts);
                end
                else begin
                    cos_acc = cos_acc + longint'(tc);
                    sin_acc = sin_acc + longint'(ts);
                end
            end
            c = round_to_q16(cos_acc);
            s = round_to_q16(sin_acc);
            case (quad % 4)
                0: begin dir_cos[k] = c;  dir_sin[k] = s;  end
                1: begin dir_cos[k] = -s; dir_sin[k] = c;  end
                2: begin dir_cos[k] = -c; dir_sin[k] = -s; end
                default: begin dir_cos[k] = s; dir_sin[k] = -c; end
            endcase
        end
    endfunction

    // Radius times a Q16 direction component, truncated toward zero.
    function automatic int ray_offset(input int unsigned r, input int v);
        int unsigned mag;
        int          res;
        mag = (v < 0) ? -v : v;
        res = int'((mag * r) >> 16);
        return (v < 0) ? -res : res;
    endfunction

    function automatic int cell_index(input int cx, input int cy);
        return cy * MAP_SIDE + cx;
    endfunction

    // Cells outside the map read as blocked.
    function automatic bit cell_open(input int cx, input int cy);
        if (cx < 0 || cy < 0 || cx >= MAP_SIDE || cy >= MAP_SIDE) begin
            return 1'b0;
        end
        return cell_free_map[cell_index(cx, cy)];
    endfunction

    // Range the block should report for a cast against the current map.
    function automatic logic [RANGE_W-1:0] trace_ray_range(input logic [POS_W-1:0] ox,
                                                           input logic [POS_W-1:0] oy,
                                                           input logic [ANG_W-1:0] ang);
        int          dir;
        int unsigned r;
        dir = int'(ang) % ANGLE_STEPS;
        for (r = 0; r < range_limit; r++) begin
            if (!cell_open(int'(ox) + ray_offset(r, dir_cos[dir]),
                           int'(oy) + ray_offset(r, dir_sin[dir]))) begin
                break;
            end
        end
        return RANGE_W'(r);
    endfunction

    // Offer one item, wait for its transfer and update the predicted state.
    task automatic send_item(input logic cmd, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic free_bit,
                             input logic [ANG_W-1:0] ang);
        while ($urandom_range(99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.cmd       <= cmd;
        item_ch.pos_x     <= x;
        item_ch.pos_y     <= y;
        item_ch.cell_free <= free_bit;
        item_ch.angle_deg <= ang;
        @(posedge clk);
        while (!item_ch.ready) begin
            @(posedge clk);
        end
        items_sent++;
        if (cmd == CMD_WRITE) begin
            cell_free_map[cell_index(int'(x), int'(y))] = free_bit;
            cell_written[cell_index(int'(x), int'(y))] = 1'b1;
        end
        else begin
            pending_ranges.insert(pending_ranges.size(), trace_ray_range(x, y, ang));
        end
    endtask

    // Load every unwritten cell the ray will read, then cast it.
    task automatic cast_ray(input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oy,
                            input logic [ANG_W-1:0] ang, input int free_pct);
        int          dir;
        int          cx;
        int          cy;
        int unsigned r;
        dir = int'(ang) % ANGLE_STEPS;
        for (r = 0; r < range_limit; r++) begin
            cx = int'(ox) + ray_offset(r, dir_cos[dir]);
            cy = int'(oy) + ray_offset(r, dir_sin[dir]);
            if (cx < 0 || cy < 0 || cx >= MAP_SIDE || cy >= MAP_SIDE) begin
                break;
            end
            if (!cell_written[cell_index(cx, cy)]) begin
                send_item(CMD_WRITE, POS_W'(cx), POS_W'(cy), $urandom_range(99) < free_pct,
                          ANG_W'($urandom_range(2 ** ANG_W - 1)));
            end
            if (!cell_free_map[cell_index(cx, cy)]) begin
                break;
            end
        end
        send_item(CMD_CAST, ox, oy, 1'($urandom_range(1)), ang);
    endtask

    // Stop offering, wait for every result, then let trailing writes retire.
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        while (pending_ranges.size() != 0) begin
            @(posedge clk);
        end
        repeat (WRITE_SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_max_range();
        logic [APB_DW-1:0] got;
        apb_read(MAX_RANGE_ADDR, got);
        if (got[RANGE_W-1:0] !== RANGE_W'(range_limit)) begin
            errors++;
            $display("%0t: max_range read expected %0d actual %0d",
                     $time, range_limit, got[RANGE_W-1:0]);
        end
    endtask

    // Only the low byte of the written word is kept.
    task automatic set_max_range(input logic [APB_DW-1:0] value);
        apb_write(MAX_RANGE_ADDR, value);
        range_limit = int'(value[RANGE_W-1:0]);
        check_max_range();
    endtask

    // Short rays at the map corners and edges, wrapped angles, a blocked origin.
    task automatic test_edge_rays();
        check_max_range();
        send_item(CMD_WRITE, '0, '0, 1'b1, ANGLE_TOP);
        send_item(CMD_WRITE, EDGE_HI, EDGE_HI, 1'b1, '0);
        send_item(CMD_WRITE, EDGE_HI, '0, 1'b1, 9'd200);
        send_item(CMD_WRITE, '0, EDGE_HI, 1'b1, 9'd17);
        send_item(CMD_WRITE, 9'd256, 9'd256, 1'b0, 9'd256);
        cast_ray(EDGE_HI, EDGE_HI, 9'd0, 100);
        cast_ray('0, '0, 9'd180, 100);
        cast_ray('0, EDGE_HI, 9'd90, 100);
        cast_ray(EDGE_HI, '0, 9'd270, 100);
        cast_ray(EDGE_HI, EDGE_HI, 9'd360, 100);
        cast_ray('0, '0, ANGLE_TOP, 100);
        cast_ray(EDGE_HI, '0, 9'd359, 100);
        cast_ray('0, EDGE_HI, 9'd135, 100);
        cast_ray(9'd256, 9'd256, 9'd45, 100);
        drain_results();
    endtask

    // Spare register index, zero range, unit range and the longest range.
    task automatic test_range_register();
        apb_write(SPARE_ADDR, '1);
        check_max_range();
        set_max_range(32'd0);
        cast_ray(9'd256, 9'd256, 9'd10, 100);
        cast_ray(EDGE_HI, EDGE_HI, 9'd200, 100);
        drain_results();
        set_max_range(32'd1);
        cast_ray(9'd256, 9'd256, 9'd300, 100);
        cast_ray(EDGE_HI, EDGE_HI, 9'd77, 100);
        cast_ray('0, '0, 9'd300, 100);
        drain_results();
        set_max_range(32'd255);
        cast_ray('0, 9'd300, 9'd0, 100);
        cast_ray('0, 9'd301, 9'd0, 97);
        drain_results();
    endtask

    // Random casts, mostly from a small patch so that rays share loaded cells.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [APB_DW-1:0] range_word,
                                       input int free_pct, input int count);
        int               phase_end;
        int               pick;
        int               base_x;
        int               base_y;
        logic [POS_W-1:0] ox;
        logic [POS_W-1:0] oy;
        logic [ANG_W-1:0] ang;
        set_max_range(range_word);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        phase_end = items_sent + count;
        base_x = $urandom_range(MAP_SIDE - WINDOW);
        base_y = $urandom_range(MAP_SIDE - WINDOW);
        while (items_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                // Stray writes, some of them overwriting cells that rays use.
                if (pick < 6) begin
                    ox = POS_W'($urandom_range(MAP_SIDE - 1));
                    oy = POS_W'($urandom_range(MAP_SIDE - 1));
                end
                else begin
                    ox = POS_W'(base_x + $urandom_range(WINDOW - 1));
                    oy = POS_W'(base_y + $urandom_range(WINDOW - 1));
                end
                send_item(CMD_WRITE, ox, oy, $urandom_range(99) < free_pct,
                          ANG_W'($urandom_range(2 ** ANG_W - 1)));
            end
            else begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    ox = POS_W'(base_x + $urandom_range(WINDOW - 1));
                    oy = POS_W'(base_y + $urandom_range(WINDOW - 1));
                end
                else if (pick < 93) begin
                    ox = POS_W'($urandom_range(MAP_SIDE - 1));
                    oy = POS_W'($urandom_range(MAP_SIDE - 1));
                end
                else begin
                    ox = $urandom_range(1) ? EDGE_HI : '0;
                    oy = POS_W'($urandom_range(MAP_SIDE - 1));
                end
                if ($urandom_range(99) < 8) begin
                    ang = ANG_W'($urandom_range(2 ** ANG_W - 1, ANGLE_STEPS));
                end
                else begin
                    ang = ANG_W'($urandom_range(ANGLE_STEPS - 1));
                end
                cast_ray(ox, oy, ang, free_pct);
            end
        end
        drain_results();
    endtask

    // Results are held off while casts keep coming, so the block stalls its input.
    task automatic test_backpressure();
        int base_x;
        int base_y;
        set_max_range(32'd40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        base_x = $urandom_range(MAP_SIDE - WINDOW);
        base_y = $urandom_range(MAP_SIDE - WINDOW);
        hold_left = HOLD_CYCLES;
        repeat (16) begin
            cast_ray(POS_W'(base_x + $urandom_range(WINDOW - 1)),
                     POS_W'(base_y + $urandom_range(WINDOW - 1)),
                     ANG_W'($urandom_range(ANGLE_STEPS - 1)), 90);
        end
        // The sender waits here until every result has come back.
        drain_results();
        send_idle_pct = 33;
        recv_idle_pct = 48;
        repeat (8) begin
            cast_ray(POS_W'(base_x + $urandom_range(WINDOW - 1)),
                     POS_W'(base_y + $urandom_range(WINDOW - 1)),
                     ANG_W'($urandom_range(ANGLE_STEPS - 1)), 90);
        end
        drain_results();
    endtask

    // Result receiver: random ready, or a long hold-off when one is requested.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end
        else begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest predicted range.
    always @(posedge clk) begin : result_check
        logic [RANGE_W-1:0] want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_ranges.size() == 0) begin
                errors++;
                $display("%0t: range_cells expected none actual %0d",
                         $time, result_ch.range_cells);
            end
            else begin
                want = pending_ranges.pop_front();
                if (result_ch.range_cells !== want) begin
                    errors++;
                    $display("%0t: range_cells expected %0d actual %0d",
                             $time, want, result_ch.range_cells);
                end
            end
        end
    end

    // End the run when no transfer happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            quiet_cycles = 0;
        end
        else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("grid_ray_cast_range: mismatch");
            $finish;
        end
    end

    initial begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        item_ch.valid     = 1'b0;
        item_ch.cmd       = CMD_WRITE;
        item_ch.pos_x     = '0;
        item_ch.pos_y     = '0;
        item_ch.cell_free = 1'b0;
        item_ch.angle_deg = '0;
        result_ch.ready   = 1'b0;
        build_direction_tables();
        range_limit = int'(MAX_RANGE_RESET);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_rays();
        test_range_register();
        test_random_traffic(33, 48, {24'hA5A5A5, 8'd80}, 85, 190);
        test_random_traffic(48, 33, 32'($urandom_range(254, 2)), 90, 190);
        test_random_traffic(0, 0, 32'd255, 80, 190);
        test_backpressure();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("grid_ray_cast_range: match");
        end
        else begin
            $display("grid_ray_cast_range: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
